// File: rtl/core/stts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted term table set: shared package
// Payload structs, status and command codes, and the state and handshake
// types used between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stts_pkg;

	// Fixed field widths of the request and response.
	localparam int EXP_WIDTH = 32;
	localparam int IN_COEFF_WIDTH = 32;
	localparam int STATUS_WIDTH = 3;
	localparam int COUNT_WIDTH = 7;
	// Width used to sign-extend the incoming coefficient before trimming.
	localparam int SEXT_WIDTH = 64;

	// Defaults for the top-level parameters.
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_COEFF_WIDTH = 32;

	typedef struct packed {
		logic [EXP_WIDTH-1:0]             term_exponent;
		logic signed [IN_COEFF_WIDTH-1:0] term_coefficient;
	} req_t;

	typedef struct packed {
		logic [STATUS_WIDTH-1:0] status;
		logic [COUNT_WIDTH-1:0]  term_count;
	} rsp_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_REPLACED = 3'd0,
		ST_INSERTED = 3'd1,
		ST_DELETED  = 3'd2,
		ST_NOCHANGE = 3'd3,
		ST_FULL     = 3'd4
	} status_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT_UP,
		S_WRITE_POS,
		S_SHIFT_DN,
		S_FINISH
	} state_e;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SEARCH,
		CMD_START_UP,
		CMD_SHIFT_UP,
		CMD_WRITE_POS,
		CMD_START_DN,
		CMD_SHIFT_DN
	} cmd_e;

	// Controller to datapath.
	typedef struct packed {
		cmd_e    cmd;
		logic    finish;
		status_e status;
	} dp_ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic found;
		logic last;
		logic hit;
		logic zero;
		logic up_done;
		logic dn_single;
		logic dn_done;
		logic at_end;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_term_table_set.sv
// A replace, a miss or a full table runs a search over the stored entries (none for an
// empty table), a decide step and a finish step that waits for a free response register.
// An insert also moves each later term up and then writes the new term; a delete
// moves each later term down. The block takes one request at a time and is ready
// for the next in the same cycle as its response turns valid.
// Reset clears the term count and the response valid; memory contents need none.
// ----------------------------------------------------------------------------
// Sorted term table set: top level
// Keeps a sparse polynomial as terms sorted by exponent and applies replace,
// insert and delete requests, returning a status and the new term count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_term_table_set import stts_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int COEFF_WIDTH = DEF_COEFF_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp_data
);

	dp_ctl_t ctl;
	dp_sts_t sts;

	stts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	stts_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.rsp_ready(rsp_ready),
		.rsp_valid(rsp_valid),
		.rsp_data (rsp_data),
		.ctl      (ctl),
		.sts      (sts)
	);

endmodule

`default_nettype wire

// File: rtl/core/stts_ram.sv
// ----------------------------------------------------------------------------
// Sorted term table set: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/stts_datapath.sv
// ----------------------------------------------------------------------------
// Sorted term table set: datapath
// Holds the request, the term count, the search and shift index, the term
// memory and the response register; acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module stts_datapath import stts_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int COEFF_WIDTH = DEF_COEFF_WIDTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire req_t    req_data,
	input  wire logic    rsp_ready,
	output logic         rsp_valid,
	output rsp_t         rsp_data,
	input  wire dp_ctl_t ctl,
	output dp_sts_t      sts
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = EXP_WIDTH + COEFF_WIDTH;

	logic [EXP_WIDTH-1:0]   ex_q;
	logic [COEFF_WIDTH-1:0] cf_q;
	logic                   zero_q;
	logic [CW-1:0]          k_q;
	logic [CW-1:0]          pos_q;
	logic                   hit_q;
	logic [CW-1:0]          n_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [SEXT_WIDTH-1:0]  cf_ext;
	logic [CW-1:0]          rd_idx;
	logic [CW-1:0]          n_next;
	logic                   we;
	logic [CW-1:0]          wr_idx;
	logic [DW-1:0]          wdata;
	logic [DW-1:0]          rdata;
	logic [EXP_WIDTH-1:0]   rd_exp;
	logic                   rsp_load;

	// Sign-extend the incoming coefficient, then keep the stored width.
	assign cf_ext = SEXT_WIDTH'(req_data.term_coefficient);
	assign rd_exp = rdata[DW-1 -: EXP_WIDTH];
	assign rsp_load = ctl.finish;

	// Read address for the entry needed in the following cycle.
	always_comb begin
		case (ctl.cmd)
			CMD_LOAD:     rd_idx = '0;
			CMD_SEARCH:   rd_idx = k_q + CW'(1);
			CMD_START_UP: rd_idx = n_q - CW'(1);
			CMD_SHIFT_UP: rd_idx = k_q - CW'(2);
			CMD_START_DN: rd_idx = pos_q + CW'(1);
			CMD_SHIFT_DN: rd_idx = k_q + CW'(2);
			default:      rd_idx = k_q;
		endcase
	end

	// Write port: the new term at its slot, or a moved entry during a shift.
	always_comb begin
		we = 1'b0;
		wr_idx = k_q;
		wdata = rdata;
		case (ctl.cmd)
			CMD_WRITE_POS: begin
				we = 1'b1;
				wr_idx = pos_q;
				wdata = {ex_q, cf_q};
			end
			CMD_SHIFT_UP, CMD_SHIFT_DN: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	stts_ram #(
		.WIDTH(DW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wr_idx[AW-1:0]),
		.wdata(wdata),
		.raddr(rd_idx[AW-1:0]),
		.rdata(rdata)
	);

	// Count after the operation that is being reported.
	always_comb begin
		case (ctl.status)
			ST_INSERTED: n_next = n_q + CW'(1);
			ST_DELETED:  n_next = n_q - CW'(1);
			default:     n_next = n_q;
		endcase
	end

	// Request fields and the search and shift index.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				ex_q <= req_data.term_exponent;
				cf_q <= cf_ext[COEFF_WIDTH-1:0];
				zero_q <= (req_data.term_coefficient == '0);
				k_q <= '0;
				pos_q <= '0;
				hit_q <= 1'b0;
			end
			CMD_SEARCH: begin
				k_q <= k_q + CW'(1);
				if (rd_exp >= ex_q) begin
					pos_q <= k_q;
					hit_q <= (rd_exp == ex_q);
				end else if (sts.last) begin
					pos_q <= n_q;
					hit_q <= 1'b0;
				end
			end
			CMD_START_UP: k_q <= n_q;
			CMD_SHIFT_UP: k_q <= k_q - CW'(1);
			CMD_START_DN: k_q <= pos_q;
			CMD_SHIFT_DN: k_q <= k_q + CW'(1);
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// Term count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				n_q <= n_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status <= ctl.status;
			rsp_q.term_count <= COUNT_WIDTH'(n_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

	// Status back to the controller.
	always_comb begin
		sts.empty = (n_q == '0);
		sts.full = (n_q == CW'(TABLE_DEPTH));
		sts.found = (rd_exp >= ex_q);
		sts.last = ((k_q + CW'(1)) == n_q);
		sts.hit = hit_q;
		sts.zero = zero_q;
		sts.up_done = ((k_q - CW'(1)) == pos_q);
		sts.dn_single = ((pos_q + CW'(1)) == n_q);
		sts.dn_done = ((k_q + CW'(2)) == n_q);
		sts.at_end = (pos_q == n_q);
		sts.out_free = !rsp_valid_q || rsp_ready;
	end

endmodule

`default_nettype wire

// File: rtl/core/stts_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted term table set: controller
// Sequences search, replace, insert with upward shift and delete with
// downward shift, and hands the result to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module stts_ctrl import stts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire dp_sts_t sts,
	output dp_ctl_t      ctl
);

	state_e  state_q;
	state_e  state_d;
	status_e status_q;
	status_e status_d;

	// State and held status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_NOCHANGE;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
		end
	end

	// Next state and the status to report.
	always_comb begin
		state_d = state_q;
		status_d = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = sts.empty ? S_DECIDE : S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.found || sts.last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				if (!sts.zero) begin
					if (sts.hit) begin
						status_d = ST_REPLACED;
					end else if (sts.full) begin
						status_d = ST_FULL;
					end else begin
						status_d = ST_INSERTED;
						state_d = sts.at_end ? S_WRITE_POS : S_SHIFT_UP;
					end
				end else if (sts.hit) begin
					status_d = ST_DELETED;
					if (!sts.dn_single) begin
						state_d = S_SHIFT_DN;
					end
				end else begin
					status_d = ST_NOCHANGE;
				end
			end
			S_SHIFT_UP: begin
				if (sts.up_done) begin
					state_d = S_WRITE_POS;
				end
			end
			S_WRITE_POS: begin
				state_d = S_FINISH;
			end
			S_SHIFT_DN: begin
				if (sts.dn_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		req_ready = 1'b0;
		ctl.cmd = CMD_NONE;
		ctl.finish = 1'b0;
		ctl.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.cmd = CMD_LOAD;
				end
			end
			S_SEARCH: begin
				ctl.cmd = CMD_SEARCH;
			end
			S_DECIDE: begin
				if (!sts.zero) begin
					if (sts.hit) begin
						ctl.cmd = CMD_WRITE_POS;
					end else if (!sts.full) begin
						// The slot at the end needs no shift.
						ctl.cmd = sts.at_end ? CMD_NONE : CMD_START_UP;
					end
				end else if (sts.hit && !sts.dn_single) begin
					ctl.cmd = CMD_START_DN;
				end
			end
			S_SHIFT_UP: begin
				ctl.cmd = CMD_SHIFT_UP;
			end
			S_WRITE_POS: begin
				ctl.cmd = CMD_WRITE_POS;
			end
			S_SHIFT_DN: begin
				ctl.cmd = CMD_SHIFT_DN;
			end
			S_FINISH: begin
				ctl.finish = sts.out_free;
			end
			default: begin
				ctl.cmd = CMD_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sim/sorted_term_table_set_tb.sv
// ----------------------------------------------------------------------------
// Sorted term table set: testbench
// Sends set requests (replace, insert, delete, miss, full table) to the
// block and checks every response against a local model of the sorted term
// table, or a directed row's own expected response. A short directed table
// runs first. Random episodes then alternately fill the table past capacity
// and drain it again. Both handshake sides stall randomly in changing ratios.
// ----------------------------------------------------------------------------
module sorted_term_table_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stts_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;
	localparam int CW = DEF_COEFF_WIDTH;
	localparam int NUM_RANDOM = 1232;
	localparam int EPISODE_LEN = 120;
	localparam int POOL_SIZE = 80;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

	// One row of the directed table. Rows with has_expect set carry their
	// own expected response; the others are checked against the model.
	typedef struct packed {
		logic [EXP_WIDTH-1:0]      ex;
		logic [IN_COEFF_WIDTH-1:0] cf;
		logic                      has_expect;
		status_e                   st;
		logic [COUNT_WIDTH-1:0]    cnt;
	} dir_row_t;

	localparam int NUM_DIRECTED = 18;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// Local copy of the term table.
	logic [EXP_WIDTH-1:0] held_exp [DEPTH];
	logic [CW-1:0]        held_coef [DEPTH];
	int                   term_total = 0;

	rsp_t expected_rsp [$];
	int   mismatch_count = 0;
	int   send_idle = 25;
	int   recv_idle = 48;
	rsp_t want;

	sorted_term_table_set dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one set request to the local table and returns its response.
	function automatic rsp_t apply_term(req_t rq);
		int unsigned pos;
		int k;
		logic hit;
		logic signed [SEXT_WIDTH-1:0] wide;
		logic [CW-1:0] cf;
		rsp_t r;
		wide = rq.term_coefficient;
		cf = wide[CW-1:0];
		pos = 0;
		while (pos < term_total && held_exp[pos] < rq.term_exponent)
			pos++;
		hit = (pos < term_total) && (held_exp[pos] == rq.term_exponent);
		if (rq.term_coefficient != 0) begin
			if (hit) begin
				held_coef[pos] = cf;
				r.status = ST_REPLACED;
			end else if (term_total >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				for (k = term_total; k > int'(pos); k--) begin
					held_exp[k] = held_exp[k-1];
					held_coef[k] = held_coef[k-1];
				end
				held_exp[pos] = rq.term_exponent;
				held_coef[pos] = cf;
				term_total++;
				r.status = ST_INSERTED;
			end
		end else if (hit) begin
			for (k = pos; k + 1 < term_total; k++) begin
				held_exp[k] = held_exp[k+1];
				held_coef[k] = held_coef[k+1];
			end
			term_total--;
			r.status = ST_DELETED;
		end else begin
			r.status = ST_NOCHANGE;
		end
		r.term_count = term_total[COUNT_WIDTH-1:0];
		return r;
	endfunction

	// Response side stalls at random; never ready while in reset.
	always @(posedge clk)
		rsp_ready <= arst_n && ($urandom_range(99) >= recv_idle);

	// Compare each accepted response with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected response: status %0d, term_count %0d",
					rsp_data.status, rsp_data.term_count);
				mismatch_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_data.status !== want.status) begin
					$error("status: expected %0d, actual %0d",
						want.status, rsp_data.status);
					mismatch_count++;
				end
				if (rsp_data.term_count !== want.term_count) begin
					$error("term_count: expected %0d, actual %0d",
						want.term_count, rsp_data.term_count);
					mismatch_count++;
				end
			end
		end
	end

	// Reset, directed table, random episodes, then drain and report.
	initial begin
		dir_row_t directed [NUM_DIRECTED];
		logic [EXP_WIDTH-1:0] pool [POOL_SIZE];
		logic [EXP_WIDTH-1:0] base;
		logic [EXP_WIDTH-1:0] stride;
		req_t rq;
		rsp_t predicted;
		int total;
		int idx;
		int i;
		bit draining;
		bit want_zero;

		directed = '{
			// Delete on an empty table.
			'{32'd5,          32'h0000_0000, 1'b1, ST_NOCHANGE, 7'd0},
			// Inserts and replaces at the extremes of exponent and coefficient.
			'{32'd0,          32'h7FFF_FFFF, 1'b1, ST_INSERTED, 7'd1},
			'{32'hFFFF_FFFF,  32'h8000_0000, 1'b1, ST_INSERTED, 7'd2},
			'{32'd100,        32'hFFFF_FFFF, 1'b1, ST_INSERTED, 7'd3},
			'{32'd100,        32'h0000_0001, 1'b1, ST_REPLACED, 7'd3},
			'{32'd50,         32'h0000_0007, 1'b0, ST_REPLACED, 7'd0},
			'{32'd0,          32'h8000_0000, 1'b0, ST_REPLACED, 7'd0},
			'{32'hFFFF_FFFF,  32'h7FFF_FFFF, 1'b0, ST_REPLACED, 7'd0},
			// Delete without a match, then deletes in the middle and ends.
			'{32'd99,         32'h0000_0000, 1'b0, ST_REPLACED, 7'd0},
			'{32'd100,        32'h0000_0000, 1'b0, ST_REPLACED, 7'd0},
			'{32'd0,          32'h0000_0000, 1'b0, ST_REPLACED, 7'd0},
			'{32'hFFFF_FFFF,  32'h0000_0000, 1'b0, ST_REPLACED, 7'd0},
			'{32'd50,         32'h0000_0000, 1'b0, ST_REPLACED, 7'd0},
			'{32'd50,         32'h0000_0000, 1'b1, ST_NOCHANGE, 7'd0},
			'{32'hFFFF_FFFF,  32'h0000_0001, 1'b1, ST_INSERTED, 7'd1},
			'{32'd0,          32'hFFFF_FFFE, 1'b0, ST_REPLACED, 7'd0},
			'{32'h8000_0000,  32'h1234_5678, 1'b0, ST_REPLACED, 7'd0},
			'{32'd0,          32'h0000_0000, 1'b0, ST_REPLACED, 7'd0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = NUM_DIRECTED + NUM_RANDOM;
		draining = 1'b1;
		for (idx = 0; idx < total; idx++) begin
			// Idle ratios: sender light, then receiver light, then none.
			if (idx < total / 3) begin
				send_idle = 25;
				recv_idle = 48;
			end else if (idx < 2 * total / 3) begin
				send_idle = 48;
				recv_idle = 25;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end

			if (idx < NUM_DIRECTED) begin
				rq.term_exponent = directed[idx].ex;
				rq.term_coefficient = directed[idx].cf;
			end else begin
				// A new episode alternates filling and draining over a fresh
				// pool of exponents, larger than the table so it fills up.
				if ((idx - NUM_DIRECTED) % EPISODE_LEN == 0) begin
					draining = !draining;
					stride = $urandom_range(1, 1 << $urandom_range(20));
					case ($urandom_range(3))
						0: base = 32'd0;
						1: base = 32'hFFFF_FFFF - (POOL_SIZE - 1) * stride;
						default: base = $urandom;
					endcase
					for (i = 0; i < POOL_SIZE; i++)
						pool[i] = base + i * stride;
				end
				if (draining && term_total > 0 && $urandom_range(99) < 70)
					rq.term_exponent = held_exp[$urandom_range(term_total - 1)];
				else if ($urandom_range(99) < 85)
					rq.term_exponent = pool[$urandom_range(POOL_SIZE - 1)];
				else
					rq.term_exponent = $urandom;
				want_zero = draining ? ($urandom_range(99) < 75)
					: ($urandom_range(99) < 10);
				if (want_zero) begin
					rq.term_coefficient = '0;
				end else begin
					case ($urandom_range(15))
						0: rq.term_coefficient = 32'h7FFF_FFFF;
						1: rq.term_coefficient = 32'h8000_0000;
						2: rq.term_coefficient = 32'hFFFF_FFFF;
						default: rq.term_coefficient = $urandom;
					endcase
					if (rq.term_coefficient == 0)
						rq.term_coefficient = 32'sd1;
				end
			end

			// Optional gap before the request is offered.
			while ($urandom_range(99) < send_idle) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
			req_valid <= 1'b1;
			req_data <= rq;
			@(posedge clk);
			while (!req_ready)
				@(posedge clk);

			predicted = apply_term(rq);
			if (idx < NUM_DIRECTED && directed[idx].has_expect) begin
				predicted.status = directed[idx].st;
				predicted.term_count = directed[idx].cnt;
			end
			expected_rsp.push_back(predicted);
		end
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#30ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
